// ===== rtl/ttp_pkg.sv =====
package ttp_pkg;

   // operation codes carried in req_tuser
   typedef enum logic [1:0] {
      OP_LOAD_QUERY  = 2'd0,
      OP_LOAD_FILTER = 2'd1,
      OP_TEST_NODE   = 2'd2,
      OP_TEST_LEAF   = 2'd3
   } op_type;

   // field widths
   localparam int IDX_W   = 4;
   localparam int WORD_W  = 64;
   localparam int CNT_W   = 11;
   localparam int THR_W   = 17;
   localparam int Q_FRAC  = 16;
   localparam int U_W     = CNT_W + 2;
   localparam int PROD_W  = THR_W + U_W - 1;
   localparam int MEM_DEPTH = 1 << IDX_W;

   localparam logic [THR_W-1:0] ONE_Q16   = THR_W'(65536);
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // request tdata layout, lowest bit first
   localparam int REQ_IDX_LSB  = 0;
   localparam int REQ_WORD_LSB = REQ_IDX_LSB + IDX_W;
   localparam int REQ_MIN_LSB  = REQ_WORD_LSB + WORD_W;
   localparam int REQ_MAX_LSB  = REQ_MIN_LSB + CNT_W;
   localparam int REQ_USED_W   = REQ_MAX_LSB + CNT_W;
   localparam int REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata layout, lowest bit first
   localparam int RSP_USED_W = 1 + CNT_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   // one captured request beat
   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   idx;
      logic [WORD_W-1:0]  word;
      logic               last;
      logic [CNT_W-1:0]   min_w;
      logic [CNT_W-1:0]   max_w;
   } req_type;

   // everything the decision needs once a candidate is complete
   typedef struct packed {
      logic               leaf;
      logic               hit;
      logic [CNT_W-1:0]   common;
      logic [CNT_W-1:0]   na;
      logic [CNT_W-1:0]   max_w;
      logic [CNT_W-1:0]   min_w;
   } dec_type;

endpackage

// ===== rtl/ttp_accum.sv =====
module ttp_accum #(
   parameter int FP_WORDS  = 16,
   parameter int WORD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ttp_pkg::req_type  in_item,
   output logic              in_take,
   output logic              dec_valid,
   output ttp_pkg::dec_type  dec,
   input  logic              dec_take
);

   localparam int DEPTH = (FP_WORDS < ttp_pkg::MEM_DEPTH) ? FP_WORDS : ttp_pkg::MEM_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PC_W  = $clog2(WORD_BITS + 1);
   localparam int FULL_BITS = DEPTH * WORD_BITS;

   function automatic logic [PC_W-1:0] popcnt(input logic [WORD_BITS-1:0] v);
      logic [PC_W-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         n = n + PC_W'(v[i]);
      end
      return n;
   endfunction

   logic [WORD_BITS-1:0]       q_mem_ff [DEPTH];
   logic [WORD_BITS-1:0]       f_mem_ff [DEPTH];
   logic [DEPTH-1:0]           q_vld_ff;
   logic [DEPTH-1:0]           f_vld_ff;
   logic [ttp_pkg::CNT_W-1:0]  weight_ff, weight_in;
   logic [ttp_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       hit_ff, hit_in;
   logic                       dec_valid_ff, dec_valid_in;
   ttp_pkg::dec_type           dec_ff, dec_in;

   logic                       idx_ok;
   logic [AW-1:0]              addr;
   logic [WORD_BITS-1:0]       word_m;
   logic [WORD_BITS-1:0]       q_rd;
   logic [WORD_BITS-1:0]       f_rd;
   logic [PC_W-1:0]            pc_old, pc_new, pc_and;
   logic [ttp_pkg::CNT_W:0]    sum;
   logic                       is_test;
   logic                       ends_test;
   logic                       dec_free;
   logic                       q_wr, f_wr, dec_load;

   // address decode and store reads
   assign idx_ok = int'(in_item.idx) < DEPTH;
   assign addr   = in_item.idx[AW-1:0];
   assign word_m = in_item.word[WORD_BITS-1:0];
   assign q_rd   = q_vld_ff[addr] ? q_mem_ff[addr] : '0;
   assign f_rd   = f_vld_ff[addr] ? f_mem_ff[addr] : '0;

   assign pc_old = popcnt(q_rd);
   assign pc_new = popcnt(word_m);
   assign pc_and = popcnt(word_m & q_rd);

   // handshake toward the decision stage
   assign is_test   = (in_item.op == ttp_pkg::OP_TEST_NODE) ||
                      (in_item.op == ttp_pkg::OP_TEST_LEAF);
   assign ends_test = is_test && in_item.last;
   assign dec_free  = !dec_valid_ff || dec_take;
   assign in_take   = in_valid && (!ends_test || dec_free);

   assign q_wr     = in_take && (in_item.op == ttp_pkg::OP_LOAD_QUERY) && idx_ok;
   assign f_wr     = in_take && (in_item.op == ttp_pkg::OP_LOAD_FILTER) && idx_ok;
   assign dec_load = in_take && ends_test;

   // query weight, common count and filter hit updates
   always_comb begin
      weight_in = weight_ff;
      count_in  = count_ff;
      hit_in    = hit_ff;
      sum       = {1'b0, count_ff} + (ttp_pkg::CNT_W + 1)'(pc_and);
      if (q_wr) begin
         weight_in = weight_ff - ttp_pkg::CNT_W'(pc_old) + ttp_pkg::CNT_W'(pc_new);
      end
      if (in_take && is_test && idx_ok) begin
         count_in = sum[ttp_pkg::CNT_W] ? ttp_pkg::COUNT_MAX : sum[ttp_pkg::CNT_W-1:0];
         hit_in   = hit_ff || (|(word_m & f_rd));
      end
      dec_in.leaf   = (in_item.op == ttp_pkg::OP_TEST_LEAF);
      dec_in.hit    = hit_in;
      dec_in.common = count_in;
      dec_in.na     = weight_ff;
      dec_in.max_w  = in_item.max_w;
      dec_in.min_w  = in_item.min_w;
      if (dec_load) begin
         count_in = '0;
         hit_in   = 1'b0;
      end
   end

   // decision record valid
   always_comb begin
      dec_valid_in = dec_valid_ff;
      if (dec_load) begin
         dec_valid_in = 1'b1;
      end else if (dec_take) begin
         dec_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff     <= '0;
         f_vld_ff     <= '0;
         weight_ff    <= '0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         dec_valid_ff <= 1'b0;
      end else begin
         if (q_wr) begin
            q_vld_ff[addr] <= 1'b1;
         end
         if (f_wr) begin
            f_vld_ff[addr] <= 1'b1;
         end
         weight_ff    <= weight_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         dec_valid_ff <= dec_valid_in;
      end
   end

   // fingerprint stores and decision record payload
   always_ff @(posedge clock) begin
      if (q_wr) begin
         q_mem_ff[addr] <= word_m;
      end
      if (f_wr) begin
         f_mem_ff[addr] <= word_m;
      end
      if (dec_load) begin
         dec_ff <= dec_in;
      end
   end

   assign dec_valid = dec_valid_ff;
   assign dec       = dec_ff;

`ifndef SYNTHESIS
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      dec_load |=> (count_ff == '0) && !hit_ff)
      else $error("accumulators not cleared after a result");

   a_weight_bound: assert property (@(posedge clock) disable iff (reset)
      int'(weight_ff) <= FULL_BITS)
      else $error("query weight exceeds stored bit count");
`endif

endmodule

// ===== rtl/ttp_decide.sv =====
module ttp_decide (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ttp_pkg::THR_W-1:0]         thr,
   input  logic                              dec_valid,
   input  ttp_pkg::dec_type                  dec,
   output logic                              dec_take,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_prune,
   output logic [ttp_pkg::CNT_W-1:0]         rsp_common
);

   localparam int PW = ttp_pkg::PROD_W;
   localparam int CW = ttp_pkg::CNT_W;
   localparam int UW = ttp_pkg::U_W;
   localparam int XW = PW - CW - ttp_pkg::Q_FRAC;

   logic              mul_valid_ff, mul_valid_in;
   logic [PW-1:0]     p_na_ff, p_b_ff, p_u_ff;
   logic [PW-1:0]     p_na_in, p_b_in, p_u_in;
   logic              u_neg_ff, u_zero_ff;
   logic              leaf_ff, hit_ff;
   logic [CW-1:0]     common_ff, na_ff, max_ff;
   logic [UW-1:0]     u;
   logic [CW-1:0]     b_sel;
   logic              mul_free, mul_take;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              prune_ff, prune_in;
   logic [CW-1:0]     common_out_ff;
   logic [PW-1:0]     max_sh, na_sh, c_sh;
   logic              final_test;

   assign mul_take = mul_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign mul_free = !mul_valid_ff || mul_take;
   assign dec_take = dec_valid && mul_free;

   // union size and threshold products
   always_comb begin
      u       = {2'b00, dec.na} + {2'b00, dec.max_w} - {2'b00, dec.common};
      b_sel   = dec.leaf ? dec.max_w : dec.min_w;
      p_na_in = PW'(thr) * PW'(dec.na);
      p_b_in  = PW'(thr) * PW'(b_sel);
      p_u_in  = PW'(thr) * PW'(u[UW-2:0]);
   end

   always_comb begin
      mul_valid_in = mul_valid_ff;
      if (dec_take) begin
         mul_valid_in = 1'b1;
      end else if (mul_take) begin
         mul_valid_in = 1'b0;
      end
   end

   // cross-multiplied comparisons
   always_comb begin
      max_sh = {{XW{1'b0}}, max_ff, {ttp_pkg::Q_FRAC{1'b0}}};
      na_sh  = {{XW{1'b0}}, na_ff, {ttp_pkg::Q_FRAC{1'b0}}};
      c_sh   = {{XW{1'b0}}, common_ff, {ttp_pkg::Q_FRAC{1'b0}}};
      priority if (!leaf_ff) begin
         final_test = c_sh < p_na_ff;
      end else if (u_zero_ff) begin
         final_test = 1'b0;
      end else if (u_neg_ff) begin
         final_test = 1'b1;
      end else begin
         final_test = c_sh < p_u_ff;
      end
      prune_in = (max_sh < p_na_ff) || (na_sh < p_b_ff) || !hit_ff || final_test;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (mul_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // product stage payload and response payload
   always_ff @(posedge clock) begin
      if (dec_take) begin
         p_na_ff   <= p_na_in;
         p_b_ff    <= p_b_in;
         p_u_ff    <= p_u_in;
         u_neg_ff  <= u[UW-1];
         u_zero_ff <= (u == '0);
         leaf_ff   <= dec.leaf;
         hit_ff    <= dec.hit;
         common_ff <= dec.common;
         na_ff     <= dec.na;
         max_ff    <= dec.max_w;
      end
      if (mul_take) begin
         prune_ff      <= prune_in;
         common_out_ff <= common_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_prune  = prune_ff;
   assign rsp_common = common_out_ff;

`ifndef SYNTHESIS
   a_mul_hold: assert property (@(posedge clock) disable iff (reset)
      (mul_valid_ff && !mul_take) |=> mul_valid_ff && $stable(p_na_ff) && $stable(p_u_ff))
      else $error("product stage changed while stalled");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(mul_valid_ff))
      else $error("result beat without a product stage entry");
`endif

endmodule

// ===== rtl/tanimoto_threshold_prune.sv =====
// Tanimoto threshold prune: load the query words (operation 0) and filter words
// (operation 1), then stream each candidate's words with operation 2 (internal
// node) or 3 (leaf); the beat with tlast set returns one beat with the prune
// decision and the common bit count. The block takes one beat per clock unless a
// last test beat waits for a held decision record: popcount, store update and the
// saturating accumulate all finish in the single accumulate stage, which is the
// loop that sets that rate. A result beat passes the decision record, product and
// compare registers after its last request beat enters the input register. The
// user must write the threshold on the csr channel only while no candidate is in
// flight; the block does not enforce it. Values above 1.0 act as 1.0.
module tanimoto_threshold_prune #(
   parameter int FP_WORDS  = 16,
   parameter int WORD_BITS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: tdata = word_index, fingerprint_word, least weight, greatest weight,
   // zero fill
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ttp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // request: tuser = operation
   input  logic [1:0]                         req_tuser,
   input  logic                               req_tlast,
   // response: tdata = prune, common_bits, zero fill
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ttp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // threshold write
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ttp_pkg::THR_W-1:0]          csr_data
);

   localparam int CW = ttp_pkg::CNT_W;

   logic                          in_valid_ff, in_valid_in;
   ttp_pkg::req_type              in_ff, in_in;
   logic                          in_take;
   logic [ttp_pkg::THR_W-1:0]     thr_ff, thr_in;
   logic                          req_fire;
   logic                          dec_valid, dec_take;
   ttp_pkg::dec_type              dec;
   logic                          rsp_prune;
   logic [CW-1:0]                 rsp_common;

   // input register
   assign req_tready = !in_valid_ff || in_take;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_in.op    = ttp_pkg::op_type'(req_tuser);
      in_in.idx   = req_tdata[ttp_pkg::REQ_IDX_LSB +: ttp_pkg::IDX_W];
      in_in.word  = req_tdata[ttp_pkg::REQ_WORD_LSB +: ttp_pkg::WORD_W];
      in_in.last  = req_tlast;
      in_in.min_w = req_tdata[ttp_pkg::REQ_MIN_LSB +: CW];
      in_in.max_w = req_tdata[ttp_pkg::REQ_MAX_LSB +: CW];
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end
   end

   // threshold register, clamped to 1.0
   assign csr_ready = 1'b1;
   assign thr_in    = (csr_data > ttp_pkg::ONE_Q16) ? ttp_pkg::ONE_Q16 : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         thr_ff      <= ttp_pkg::ONE_Q16;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= thr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= in_in;
      end
   end

   ttp_accum #(
      .FP_WORDS  (FP_WORDS),
      .WORD_BITS (WORD_BITS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_item   (in_ff),
      .in_take   (in_take),
      .dec_valid (dec_valid),
      .dec       (dec),
      .dec_take  (dec_take)
   );

   ttp_decide u_decide (
      .clock      (clock),
      .reset      (reset),
      .thr        (thr_ff),
      .dec_valid  (dec_valid),
      .dec        (dec),
      .dec_take   (dec_take),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_prune  (rsp_prune),
      .rsp_common (rsp_common)
   );

   assign rsp_tdata = ttp_pkg::RSP_DATA_W'({rsp_common, rsp_prune});

endmodule
